// ===== hw/rtl/eqrs_pkg.sv =====
// Shared types and constants for the QRS enhancement chain.
package eqrs_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int DERIV_SHIFT = 2;
  localparam int DERIV_HALF  = 6;

  typedef enum logic [1:0] {
    CFG_PROD_LEN    = 2'd0,
    CFG_INTEG_LEN   = 2'd1,
    CFG_INTEG_SHIFT = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_idx_t;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_DERIV = 7'b0000010,
    ST_MUL   = 7'b0000100,
    ST_IRD   = 7'b0001000,
    ST_IWR   = 7'b0010000,
    ST_OUT   = 7'b0100000,
    ST_NEXT  = 7'b1000000
  } state_t;

endpackage

// ===== hw/rtl/eqrs_stream_if.sv =====
// Valid/ready channel interfaces for the input, result and configuration channels.
interface eqrs_in_if;
  import eqrs_pkg::*;
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          last;
  modport source (output valid, output sample, output last, input ready);
  modport sink (input valid, input sample, input last, output ready);
endinterface

interface eqrs_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic               last_res;
  modport source (output valid, output value, output last_res, input ready);
  modport sink (input valid, input value, input last_res, output ready);
endinterface

interface eqrs_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [5:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/ecg_qrs_enhance_filter_chain.sv =====
// Top level of the QRS enhancement chain: derivative, neighbor product, moving integration.
// Latency: a result leaves 6 + prod_len/2 + integ_len/2 items after its sample.
// Flow: a new item is taken only in idle, once the previous one has left the chain; the
//   shared multiplier steps once per product factor, and out stalls hold the chain. A last
//   item flushes 6 + prod_len/2 + integ_len/2 extra positions: derivative, product and
//   integration positions, each padded at its own stage and passed on like an item.
// Reset: synchronous, active low. Registers return to 3/37/5; the integration
//   window is cleared lazily by a per-record fill count, so no clearing pass.
module ecg_qrs_enhance_filter_chain #(
  parameter int MAX_PROD_LEN  = 8,
  parameter int MAX_INTEG_LEN = 64
) (
  input logic clk,
  input logic rst_n,
  eqrs_in_if.sink   in_ch,
  eqrs_out_if.source out_ch,
  eqrs_cfg_if.sink  cfg_ch
);
  import eqrs_pkg::*;

  localparam int IW  = $clog2(MAX_INTEG_LEN);
  localparam int PW  = $clog2(MAX_PROD_LEN + 1);
  localparam int PIW = (MAX_PROD_LEN > 1) ? $clog2(MAX_PROD_LEN) : 1;
  localparam int CW  = IW + 2;          // startup / flush counters
  localparam int NT  = 12;

  // configuration registers (raw) and latched per-record copies
  logic [3:0] reg_prod_r;
  logic [5:0] reg_integ_r;
  logic [2:0] reg_shift_r;
  logic [PW-1:0] cur_prod_r;
  logic [IW:0]   cur_integ_r;
  logic [2:0]    cur_shift_r;
  logic          open_r;

  state_t state_r;

  logic signed [31:0] taps_r [NT];      // derivative delay line
  logic [31:0] pwin_r [MAX_PROD_LEN];   // product window
  logic [31:0] acc_r;                   // product accumulator
  logic [PIW-1:0] pk_r;
  logic [31:0] dval_r;
  logic [31:0] pval_r;
  logic [31:0] sum_r;
  logic [IW-1:0] ipos_r;
  logic [CW-1:0] cnt0_r, cnt1_r, cnt2_r;
  logic [CW-1:0] fill_r;                // entries written this record
  logic [CW-1:0] fl_r;                  // remaining flush pushes
  logic [1:0]    fst_r;                 // flush stage: 0 deriv, 1 prod, 2 integ
  logic          flushing_r;
  logic          lastin_r;
  logic          emit_r;
  logic [31:0]   res_val_r;             // result waiting for the out register

  logic [31:0] out_val_r;
  logic        out_last_r;
  logic        out_vld_r;

  // integration window memory
  logic          ram_we;
  logic [31:0]   ram_rdata;
  eqrs_ram #(.WIDTH(32), .DEPTH(MAX_INTEG_LEN)) u_iwin (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ipos_r),
    .wdata (pval_r),
    .raddr (ipos_r),
    .rdata (ram_rdata)
  );
  assign ram_we = (state_r == ST_IWR);

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = (state_r == ST_IDLE);
  assign out_ch.valid    = out_vld_r;
  assign out_ch.value    = out_val_r;
  assign out_ch.last_res = out_last_r;

  logic [PW-1:0] cp_in;
  logic [IW:0]   ci_in;
  always_comb begin
    cp_in = (reg_prod_r == 4'd0) ? PW'(1)
          : ((32'(reg_prod_r) > MAX_PROD_LEN) ? PW'(MAX_PROD_LEN) : PW'(reg_prod_r));
    ci_in = (reg_integ_r == 6'd0) ? (IW+1)'(1)
          : ((32'(reg_integ_r) > MAX_INTEG_LEN) ? (IW+1)'(MAX_INTEG_LEN)
          : (IW+1)'(reg_integ_r));
  end

  // derivative of the incoming item dnew, minus twice taps_r[5], plus taps_r[11]
  logic signed [31:0] dnew_r;           // the incoming (or padded) sample
  logic [31:0] dsum;
  always_comb begin
    dsum = 32'(dnew_r) - 32'(taps_r[5]) - 32'(taps_r[5]) + 32'(taps_r[11]);
  end

  logic [31:0] rd_old;
  assign rd_old = (32'(fill_r) > 32'(ipos_r)) ? ram_rdata : 32'd0;
  logic [31:0] sum_nxt;
  assign sum_nxt = sum_r + pval_r - rd_old;

  logic [CW-1:0] half_p, half_i;
  assign half_p = CW'(cur_prod_r >> 1);
  assign half_i = CW'(cur_integ_r >> 1);

  // final push of a flush: last of the last non-empty flush stage
  logic flush_end;
  assign flush_end = flushing_r && (fl_r == CW'(1)) &&
                     ((fst_r == 2'd2) ||
                      ((half_i == '0) && ((fst_r == 2'd1) || (half_p == '0))));

  // out register takes a new result when empty or being drained
  logic out_load;
  assign out_load = (state_r == ST_OUT) && (!out_vld_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reg_prod_r  <= 4'd3;
      reg_integ_r <= 6'd37;
      reg_shift_r <= 3'd5;
      open_r      <= 1'b0;
      state_r     <= ST_IDLE;
      out_vld_r   <= 1'b0;
      flushing_r  <= 1'b0;
      emit_r      <= 1'b0;
    end else begin
      if (out_load) out_vld_r <= 1'b1;
      else if (out_ch.ready) out_vld_r <= 1'b0;
      if (cfg_ch.valid) begin
        unique case (cfg_idx_t'(cfg_ch.index))
          CFG_PROD_LEN:    reg_prod_r  <= cfg_ch.data[3:0];
          CFG_INTEG_LEN:   reg_integ_r <= cfg_ch.data;
          CFG_INTEG_SHIFT: reg_shift_r <= cfg_ch.data[2:0];
          default: ;
        endcase
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_ch.valid) begin
            dnew_r   <= 32'(in_ch.sample);
            lastin_r <= in_ch.last;
            fst_r    <= 2'd0;
            if (!open_r) begin
              open_r      <= 1'b1;
              cur_prod_r  <= cp_in;
              cur_integ_r <= ci_in;
              cur_shift_r <= reg_shift_r;
              for (int k = 0; k < NT; k++) taps_r[k] <= '0;
              for (int k = 0; k < MAX_PROD_LEN; k++) pwin_r[k] <= 32'd1;
              sum_r  <= '0;
              ipos_r <= '0;
              cnt0_r <= '0; cnt1_r <= '0; cnt2_r <= '0;
              fill_r <= '0;
            end
            state_r <= ST_DERIV;
          end
        end
        ST_DERIV: begin
          emit_r <= 1'b0;
          if (fst_r == 2'd0) begin
            for (int k = NT-1; k > 0; k--) taps_r[k] <= taps_r[k-1];
            taps_r[0] <= dnew_r;
            if (32'(cnt0_r) < 32'(DERIV_HALF + 1)) cnt0_r <= cnt0_r + 1'b1;
            if (32'(cnt0_r) + 1 > DERIV_HALF) begin
              dval_r  <= {{DERIV_SHIFT{dsum[31]}}, dsum[31:DERIV_SHIFT]};
              state_r <= ST_MUL;
            end else state_r <= ST_NEXT;
          end else if (fst_r == 2'd1) begin
            dval_r  <= 32'd1;
            state_r <= ST_MUL;
          end else begin
            pval_r  <= '0;
            state_r <= ST_IRD;
          end
          if (fst_r != 2'd2) begin
            acc_r <= 32'd1;
            pk_r  <= '0;
          end
        end
        ST_MUL: begin
          // first pass shifts the window, then one factor per cycle
          if (pk_r == '0 && acc_r == 32'd1 && !emit_r) begin
            for (int k = MAX_PROD_LEN-1; k > 0; k--) pwin_r[k] <= pwin_r[k-1];
            pwin_r[0] <= dval_r;
            if (32'(cnt1_r) <= 32'(half_p)) cnt1_r <= cnt1_r + 1'b1;
            emit_r <= (32'(cnt1_r) + 1 > 32'(half_p));
            if (!(32'(cnt1_r) + 1 > 32'(half_p))) state_r <= ST_NEXT;
          end else begin
            acc_r <= acc_r * pwin_r[pk_r];
            if (32'(pk_r) + 1 >= 32'(cur_prod_r)) begin
              state_r <= ST_IRD;
              emit_r  <= 1'b0;
            end else pk_r <= pk_r + 1'b1;
          end
        end
        ST_IRD: begin
          if (fst_r != 2'd2) pval_r <= acc_r[31] ? (32'd0 - acc_r) : acc_r;
          state_r <= ST_IWR;
        end
        ST_IWR: begin
          sum_r <= sum_nxt;
          if (32'(fill_r) <= 32'(ipos_r)) fill_r <= CW'(32'(ipos_r) + 1);
          ipos_r <= (32'(ipos_r) + 1 >= 32'(cur_integ_r)) ? '0 : ipos_r + 1'b1;
          if (32'(cnt2_r) <= 32'(half_i)) cnt2_r <= cnt2_r + 1'b1;
          if (32'(cnt2_r) + 1 > 32'(half_i)) begin
            res_val_r <= 32'($signed(sum_nxt) >>> cur_shift_r);
            state_r   <= ST_OUT;
          end else state_r <= ST_NEXT;
        end
        ST_OUT: begin
          if (out_load) begin
            out_val_r  <= res_val_r;
            out_last_r <= flush_end;
            state_r    <= ST_NEXT;
          end
        end
        ST_NEXT: begin
          // decide the next padded push of a flush, or go idle
          if (!flushing_r && lastin_r) begin
            flushing_r <= 1'b1;
            fst_r      <= 2'd0;
            fl_r       <= CW'(DERIV_HALF);
            dnew_r     <= '0;
            state_r    <= ST_DERIV;
          end else if (flushing_r) begin
            if (fl_r > CW'(1)) begin
              fl_r    <= fl_r - 1'b1;
              state_r <= ST_DERIV;
            end else if (fst_r == 2'd0 && half_p != '0) begin
              fst_r <= 2'd1; fl_r <= half_p; state_r <= ST_DERIV;
            end else if (fst_r != 2'd2 && half_i != '0) begin
              fst_r <= 2'd2; fl_r <= half_i; state_r <= ST_DERIV;
            end else begin
              flushing_r <= 1'b0;
              open_r     <= 1'b0;
              state_r    <= ST_IDLE;
            end
          end else state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // a result never appears while the block is idle with no record open
  a_out_open: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> (open_r || $past(open_r))) else $error("result outside record");
  a_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (state_r == ST_DERIV)) else $error("accept path");
  a_ram_wr: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> $past(state_r == ST_IRD)) else $error("window write without read");
endmodule

// ===== hw/rtl/eqrs_ram.sv =====
// Generic single-port write, single-port read RAM with registered read data.
module eqrs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== tb/sv/eqrs_chain_checker.sv =====
// Checker for the QRS enhancement chain: predicts each result and compares it with the block.
`timescale 1ns / 100ps
module eqrs_chain_checker
  import eqrs_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  eqrs_in_if   in_mon,
  eqrs_out_if  out_mon,
  eqrs_cfg_if  cfg_mon,
  output int   fail_count,
  output int   pending
);

  localparam int NTAPS     = 13;
  localparam int PROD_MAX  = 8;
  localparam int INTEG_MAX = 64;

  typedef struct packed {
    logic [31:0] value;
    logic        last_res;
  } enh_res_t;

  enh_res_t enh_expected[$];

  // register copies, and the settings latched at record start
  logic [3:0]  prod_reg;
  logic [5:0]  integ_reg;
  logic [2:0]  shift_reg;
  int unsigned prod_n, integ_n, shift_n;
  bit          rec_open;

  logic [31:0] dtaps[NTAPS-1];
  logic [31:0] pwin[PROD_MAX];
  logic [31:0] iwin[INTEG_MAX];
  int unsigned ipos;
  logic [31:0] wsum;
  int unsigned fill[3];

  function automatic logic [31:0] asr(logic [31:0] v, int unsigned s);
    return $signed(v) >>> s;
  endfunction

  function void open_record();
    prod_n  = (prod_reg == 0) ? 1 : prod_reg;
    if (prod_n > PROD_MAX) prod_n = PROD_MAX;
    integ_n = (integ_reg == 0) ? 1 : integ_reg;
    if (integ_n > INTEG_MAX) integ_n = INTEG_MAX;
    shift_n = shift_reg;
    foreach (dtaps[k]) dtaps[k] = '0;
    foreach (pwin[k]) pwin[k] = 32'd1;
    foreach (iwin[k]) iwin[k] = '0;
    ipos = 0;
    wsum = '0;
    foreach (fill[k]) fill[k] = 0;
    rec_open = 1'b1;
  endfunction

  function void push_integ(logic [31:0] v);
    wsum = wsum + v - iwin[ipos];
    iwin[ipos] = v;
    ipos++;
    if (ipos >= integ_n) ipos = 0;
    fill[2]++;
    if (fill[2] > integ_n / 2) enh_expected.push_back('{asr(wsum, shift_n), 1'b0});
  endfunction

  function void push_prod(logic [31:0] v);
    logic [31:0] p;
    p = 32'd1;
    for (int k = PROD_MAX - 1; k > 0; k--) pwin[k] = pwin[k-1];
    pwin[0] = v;
    fill[1]++;
    if (fill[1] > prod_n / 2) begin
      for (int k = 0; k < prod_n; k++) p = p * pwin[k];
      if (p[31]) p = -p;  // most negative stays itself
      push_integ(p);
    end
  endfunction

  function void push_deriv(logic [31:0] v);
    logic [31:0] acc;
    acc = v - (dtaps[5] << 1) + dtaps[11];
    for (int k = NTAPS - 2; k > 0; k--) dtaps[k] = dtaps[k-1];
    dtaps[0] = v;
    fill[0]++;
    if (fill[0] > NTAPS / 2) push_prod(asr(acc, DERIV_SHIFT));
  endfunction

  function void take_sample(logic [15:0] s, logic last);
    int n0;
    n0 = enh_expected.size();
    if (!rec_open) open_record();
    push_deriv({{16{s[15]}}, s});
    if (last) begin
      for (int k = 0; k < NTAPS / 2; k++) push_deriv(32'd0);
      for (int k = 0; k < prod_n / 2; k++) push_prod(32'd1);
      for (int k = 0; k < integ_n / 2; k++) push_integ(32'd0);
      if (enh_expected.size() > n0) enh_expected[enh_expected.size()-1].last_res = 1'b1;
      rec_open = 1'b0;
    end
  endfunction

  always @(posedge clk) begin
    enh_res_t want;
    if (!rst_n) begin
      prod_reg  = 4'd3;
      integ_reg = 6'd37;
      shift_reg = 3'd5;
      open_record();
      rec_open = 1'b0;
      enh_expected.delete();
      fail_count <= 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (enh_expected.size() == 0) begin
          $display("%0t unexpected result: value %h last %0d", $time,
                   out_mon.value, out_mon.last_res);
          fail_count <= fail_count + 1;
        end else begin
          want = enh_expected.pop_front();
          if (want.value !== out_mon.value || want.last_res !== out_mon.last_res) begin
            $display("%0t mismatch: expected value %h last %0d, actual value %h last %0d",
                     $time, want.value, want.last_res, out_mon.value, out_mon.last_res);
            fail_count <= fail_count + 1;
          end
        end
      end
      // a sample accepted with a register write still sees the old setting
      if (in_mon.valid && in_mon.ready) take_sample(in_mon.sample, in_mon.last);
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_idx_t'(cfg_mon.index))
          CFG_PROD_LEN:    prod_reg  = cfg_mon.data[3:0];
          CFG_INTEG_LEN:   integ_reg = cfg_mon.data[5:0];
          CFG_INTEG_SHIFT: shift_reg = cfg_mon.data[2:0];
          default: ;
        endcase
      end
    end
    pending <= enh_expected.size();
  end

endmodule

// ===== tb/sv/tb_ecg_qrs_enhance_filter_chain.sv =====
// Testbench top for the QRS enhancement chain: stimulus, flow control and verdict.
`timescale 1ns / 100ps
module tb_ecg_qrs_enhance_filter_chain;
  import eqrs_pkg::*;

  localparam int TOTAL_ITEMS = 430;
  localparam int STALL_LIMIT = 20000;  // cycles with no handshake at all
  localparam int DRAIN_WAIT  = 200;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  eqrs_in_if   in_ch();
  eqrs_out_if  out_ch();
  eqrs_cfg_if  cfg_ch();

  int fail_count;
  int pending;
  int items_sent;
  int in_idle_pct, out_stall_pct;
  logic hold_req = 1'b0;
  int   hold_cnt;
  int   quiet_cycles;

  ecg_qrs_enhance_filter_chain DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  eqrs_chain_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_mon    (cfg_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: random stalls, plus one long hold-off on request so the chain backs up.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_cnt     <= 0;
      out_ch.ready <= 1'b0;
    end else if (hold_req) begin
      hold_cnt     <= 400;
      out_ch.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt     <= hold_cnt - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  // Watchdog: any handshake resets the count.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || !rst_n) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // One item on the sample channel; valid stays up into the next item unless we idle.
  task automatic send_sample(logic [15:0] s, logic last);
    in_ch.valid  <= 1'b1;
    in_ch.sample <= s;
    in_ch.last   <= last;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    if ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Wait until the chain is empty: every owed result seen, then some slack.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [5:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_regs(logic [5:0] prod, logic [5:0] integ, logic [5:0] shift);
    write_reg(CFG_PROD_LEN, prod);
    write_reg(CFG_INTEG_LEN, integ);
    write_reg(CFG_INTEG_SHIFT, shift);
  endtask

  // Mix of full-range, small-signal and rail values.
  function automatic logic [15:0] pick_sample();
    case ($urandom_range(9))
      0:       return 16'h7fff;
      1:       return 16'h8000;
      2, 3, 4: return 16'($urandom_range(400)) - 16'd200;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_record(int len);
    for (int k = 0; k < len; k++) send_sample(pick_sample(), k == len - 1);
  endtask

  initial begin
    int rec_len;
    in_ch.valid   = 1'b0;
    in_ch.sample  = '0;
    in_ch.last    = 1'b0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = CFG_PROD_LEN;
    cfg_ch.data   = '0;
    items_sent    = 0;
    in_idle_pct   = 0;
    out_stall_pct = 0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset settings, one-sample record, rails.
    send_sample(16'h7fff, 1'b1);
    drain();
    send_sample(16'h8000, 1'b0);
    send_sample(16'h7fff, 1'b0);
    send_sample(16'h0000, 1'b0);
    send_sample(16'hffff, 1'b1);
    drain();
    // zero lengths act as one, shift at its top
    set_regs(6'd0, 6'd0, 6'd7);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h7fff, 1'b1);
    drain();
    // oversize product length clamps, widest window, shift six
    set_regs(6'd15, 6'd63, 6'd6);
    for (int k = 0; k < 6; k++) send_sample(k[0] ? 16'h7fff : 16'h8000, k == 5);
    drain();
    // even window, no shift; a write mid-record (chain quiet) only lands on the next record
    set_regs(6'd8, 6'd2, 6'd0);
    send_sample(16'h1234, 1'b0);
    send_sample(16'h8000, 1'b0);
    drain();
    write_reg(CFG_PROD_LEN, 6'd1);
    send_sample(16'h7fff, 1'b0);
    send_sample(16'hedcb, 1'b1);
    drain();

    // Random records through four flow-control phases.
    for (int ph = 0; items_sent < TOTAL_ITEMS; ph++) begin
      case (ph % 4)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 52; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 52; end
        default: begin in_idle_pct = 32; out_stall_pct = 32; end
      endcase
      for (int r = 0; r < 3 && items_sent < TOTAL_ITEMS; r++) begin
        if ($urandom_range(3) == 0)
          set_regs($urandom_range(1) ? 6'd1 : 6'd8, $urandom_range(1) ? 6'd1 : 6'd63,
                   $urandom_range(1) ? 6'd0 : 6'd7);
        else
          set_regs(6'($urandom_range(15)), 6'($urandom_range(63)), 6'($urandom_range(7)));
        rec_len = ($urandom_range(5) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 25);
        if (ph == 2 && r == 0) begin
          // Long hold-off on results while samples keep coming.
          hold_req <= 1'b1;
          @(posedge clk);
          hold_req <= 1'b0;
          rec_len = 60;
        end
        send_record(rec_len);
        drain();
      end
    end

    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
